/* hw/rtl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the reverse-Polish evaluator
// Opcode names, the queued token record and fixed-point constants.
// ----------------------------------------------------------------------------
package rpn_pkg;

    typedef enum logic [3:0] {
        OP_NUM    = 4'd0,
        OP_VAR    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_ADD    = 4'd4,
        OP_SUB    = 4'd5,
        OP_PASS   = 4'd6,
        OP_NEG    = 4'd7,
        OP_LT     = 4'd8,
        OP_LE     = 4'd9,
        OP_GT     = 4'd10,
        OP_GE     = 4'd11,
        OP_EQ     = 4'd12,
        OP_NE     = 4'd13,
        OP_ASSIGN = 4'd14,
        OP_SELECT = 4'd15
    } opcode_t;

    // Token as it travels from front to back
    typedef struct packed {
        opcode_t     opcode;
        logic [1:0]  arity;
        logic [31:0] token_value;
        logic        last_token;
        logic        is_op;
    } token_t;

    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Saturate a 34-bit signed value to 32 bits
    function automatic logic [31:0] sat34(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = SAT_MAX;
        else if (v < -34'sh0_8000_0000)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* hw/rtl/rpn_front.sv */
// ----------------------------------------------------------------------------
// rpn_front: token intake and classification
// Accepts tokens, tags operators, and feeds a two-entry queue to the back end.
// ----------------------------------------------------------------------------
module rpn_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        opcode,
    input  logic [1:0]        arity,
    input  logic [31:0]       token_value,
    input  logic              last_token,
    output logic              q_valid,
    output rpn_pkg::token_t   q_token,
    input  logic              q_pop
);
    import rpn_pkg::*;

    token_t     q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    token_t     tok;

    // Classify the incoming token
    always_comb
    begin
        tok.opcode      = opcode_t'(opcode);
        tok.arity       = arity;
        tok.token_value = token_value;
        tok.last_token  = last_token;
        tok.is_op       = !(opcode == OP_NUM || opcode == OP_VAR || opcode == OP_ASSIGN);
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_token  = q_mem_reg[rd_ptr_reg];

    // Store queued tokens
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= tok;
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

/* hw/rtl/rpn_divider.sv */
// ----------------------------------------------------------------------------
// rpn_divider: iterative signed Q16.16 divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import rpn_pkg::*;

    logic [47:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;
    logic [47:0] qmag;
    logic signed [49:0] qs;

    // One restoring step
    always_comb
    begin
        trial    = {rem_reg[31:0], num_reg[47]};
        num_next = {num_reg[46:0], 1'b0};
        rem_next = trial;
        if (trial >= {1'b0, den_reg})
        begin
            rem_next    = trial - {1'b0, den_reg};
            num_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd47;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    // Load magnitudes, then shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {(dividend[31] ? 32'(-dividend) : dividend), 16'd0};
            den_reg <= divisor[31] ? 32'(-divisor) : divisor;
            rem_reg <= 33'd0;
            neg_reg <= dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    // Apply sign and saturate
    always_comb
    begin
        qmag = num_reg;
        qs   = neg_reg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
        if (qs > 50'sh7FFF_FFFF)
            quotient = SAT_MAX;
        else if (qs < -50'sh8000_0000)
            quotient = SAT_MIN;
        else
            quotient = qs[31:0];
    end
endmodule

/* hw/rtl/rpn_back.sv */
// ----------------------------------------------------------------------------
// rpn_back: token execution
// Pops operands one at a time, runs the ALU, pushes and emits results.
// ----------------------------------------------------------------------------
module rpn_back #(
    parameter int STACK_DEPTH = 16,
    parameter int VAR_COUNT   = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  rpn_pkg::token_t   q_token,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       result_value,
    output logic              stack_fault,
    output logic              divide_fault
);
    import rpn_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_POP  = 7'b0000010,
        S_WAIT = 7'b0000100,
        S_EXEC = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    token_t          tok_reg;
    logic [31:0]     stack_mem [STACK_DEPTH];
    logic [31:0]     var_mem [VAR_COUNT];
    logic [VAR_COUNT-1:0] var_ok_reg;
    logic [SPW-1:0]  sp_reg;
    logic [31:0]     latest_reg;
    logic            sfault_reg, dfault_reg;
    logic [31:0]     p_reg [1:3];
    logic [1:0]      k_reg;
    logic [31:0]     rd_reg;
    logic [31:0]     var_rd_reg;
    logic            var_hit_reg;
    logic signed [63:0] prod_reg;
    logic            div_start, div_done;
    logic [31:0]     div_q;
    logic            outv_reg;
    logic [31:0]     res_reg;
    logic            sf_out_reg, df_out_reg;

    logic signed [31:0] a, b;
    logic signed [33:0] a34, b34;
    logic [31:0]     r;
    logic signed [16:0] vint;
    logic            vidx_ok;
    logic [VAW-1:0]  vidx;
    logic signed [16:0] aint;
    logic            aidx_ok;
    logic [VAW-1:0]  aidx;
    logic signed [63:0] prod_rnd;
    logic signed [47:0] prod_sh;

    assign a   = p_reg[1];
    assign b   = p_reg[2];
    assign a34 = {{2{a[31]}}, a};
    assign b34 = {{2{b[31]}}, b};

    // Variable index from the integer part, truncated toward zero
    always_comb
    begin
        vint = $signed(tok_reg.token_value[31:16]) +
               17'((tok_reg.token_value[31] && tok_reg.token_value[15:0] != 16'd0) ? 1 : 0);
        vidx_ok = (vint >= 0) && (vint < VAR_COUNT);
        vidx = vint[VAW-1:0];
        aint = $signed(a[31:16]) + 17'((a[31] && a[15:0] != 16'd0) ? 1 : 0);
        aidx_ok = (aint >= 0) && (aint < VAR_COUNT);
        aidx = aint[VAW-1:0];
    end

    // Rounded product from the registered multiply
    always_comb
    begin
        prod_rnd = prod_reg + 64'sd32768;
        prod_sh  = prod_rnd[63:16];
    end

    // Result selection
    always_comb
    begin
        case (tok_reg.opcode)
            OP_MUL:    r = (prod_sh > 48'sh7FFF_FFFF) ? SAT_MAX :
                           (prod_sh < -48'sh8000_0000) ? SAT_MIN : prod_sh[31:0];
            OP_DIV:    r = (b == 0) ? ((a > 0) ? SAT_MAX : (a < 0) ? SAT_MIN : 32'd0) : div_q;
            OP_ADD:    r = sat34(a34 + b34);
            OP_SUB:    r = sat34(a34 - b34);
            OP_PASS:   r = a;
            OP_NEG:    r = sat34(-a34);
            OP_LT:     r = (a < b) ? Q_ONE : 32'd0;
            OP_LE:     r = (a <= b) ? Q_ONE : 32'd0;
            OP_GT:     r = (a > b) ? Q_ONE : 32'd0;
            OP_GE:     r = (a >= b) ? Q_ONE : 32'd0;
            OP_EQ:     r = (a == b) ? Q_ONE : 32'd0;
            OP_NE:     r = (a != b) ? Q_ONE : 32'd0;
            OP_SELECT: r = (a != 0) ? p_reg[2] : p_reg[3];
            default:   r = 32'd0;
        endcase
    end

    assign div_start = (state_reg == S_EXEC) && tok_reg.opcode == OP_DIV && b != 0;

    // Sequence one token
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid && !outv_reg)
                        state_next = (q_token.arity == 2'd0) ? S_EXEC : S_POP;
            S_POP:  state_next = (sp_reg == '0) ? ((k_reg == 2'd1) ? S_EXEC : S_POP) : S_WAIT;
            S_WAIT: state_next = (k_reg == 2'd1) ? S_EXEC : S_POP;
            S_EXEC:
                if (tok_reg.opcode == OP_MUL)
                    state_next = S_MUL;
                else if (div_start)
                    state_next = S_DIV;
                else
                    state_next = S_DONE;
            S_MUL:  state_next = S_DONE;
            S_DIV:  if (div_done) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid && !outv_reg;

    rpn_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a),
        .divisor  (b),
        .done     (div_done),
        .quotient (div_q)
    );

    // Memory reads and writes
    always_ff @(posedge clk)
    begin
        if (state_reg == S_POP && sp_reg != '0)
            rd_reg <= stack_mem[SAW'(sp_reg - SPW'(1))];
        if (state_reg == S_EXEC)
        begin
            var_rd_reg <= var_mem[vidx];
            prod_reg   <= a * b;
        end
        if (state_reg == S_DONE)
        begin
            if (tok_reg.opcode == OP_NUM && sp_reg < STACK_DEPTH)
                stack_mem[SAW'(sp_reg)] <= tok_reg.token_value;
            else if (tok_reg.opcode == OP_VAR && sp_reg < STACK_DEPTH)
                stack_mem[SAW'(sp_reg)] <= (vidx_ok && var_hit_reg) ? var_rd_reg : 32'd0;
            else if (tok_reg.is_op && sp_reg < STACK_DEPTH)
                stack_mem[SAW'(sp_reg)] <= r;
            if (tok_reg.opcode == OP_ASSIGN && aidx_ok)
                var_mem[aidx] <= p_reg[2];
        end
    end

    // Control and token registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            latest_reg  <= '0;
            sfault_reg  <= 1'b0;
            dfault_reg  <= 1'b0;
            var_ok_reg  <= '0;
            outv_reg    <= 1'b0;
            var_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (outv_reg && !out_stall)
                outv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (q_valid && !outv_reg)
                    begin
                        tok_reg  <= q_token;
                        k_reg    <= q_token.arity;
                        p_reg[1] <= '0;
                        p_reg[2] <= '0;
                        p_reg[3] <= '0;
                    end
                S_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        sfault_reg <= 1'b1;
                        p_reg[k_reg] <= '0;
                        k_reg <= k_reg - 2'd1;
                    end
                    else
                        sp_reg <= sp_reg - SPW'(1);
                end
                S_WAIT:
                begin
                    p_reg[k_reg] <= rd_reg;
                    k_reg <= k_reg - 2'd1;
                end
                S_EXEC:
                    var_hit_reg <= var_ok_reg[vidx];
                S_DIV:
                    ;
                S_DONE:
                begin
                    if (tok_reg.opcode == OP_ASSIGN && aidx_ok)
                        var_ok_reg[aidx] <= 1'b1;
                    if (tok_reg.last_token)
                    begin
                        outv_reg   <= 1'b1;
                        res_reg    <= tok_reg.is_op ? r : latest_reg;
                        sf_out_reg <= sfault_reg || (tok_reg.opcode != OP_ASSIGN
                                                     && sp_reg >= STACK_DEPTH);
                        df_out_reg <= dfault_reg || (tok_reg.opcode == OP_DIV && b == 0);
                        sp_reg     <= '0;
                        latest_reg <= '0;
                        sfault_reg <= 1'b0;
                        dfault_reg <= 1'b0;
                    end
                    else
                    begin
                        if (tok_reg.opcode == OP_DIV && b == 0)
                            dfault_reg <= 1'b1;
                        if (tok_reg.opcode != OP_ASSIGN)
                        begin
                            if (sp_reg >= STACK_DEPTH)
                                sfault_reg <= 1'b1;
                            else
                                sp_reg <= sp_reg + SPW'(1);
                        end
                        if (tok_reg.is_op)
                            latest_reg <= r;
                    end
                end
                default: ;
            endcase
        end
    end

    // Operands that are not popped keep the zero loaded in idle
    assign out_valid    = outv_reg;
    assign result_value = res_reg;
    assign stack_fault  = sf_out_reg;
    assign divide_fault = df_out_reg;
endmodule

/* hw/rtl/rpn_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator: reverse-Polish token evaluator on signed Q16.16
// Front end queues tokens; back end pops, computes and emits on last token.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  input   | in_valid/in_stall  | opcode, arity, token_value, last_token
//  output  | out_valid/out_stall| result_value, stack_fault, divide_fault
//
// A token is registered in the queue, then the back end steps through idle,
// pop and wait per popped operand (pop alone when the stack is already empty),
// exec and done; mul adds a multiply step, divide waits on the bit-serial divider.
// Reset clears pointers, flags and variable valid bits at once; no sweep.
// A pending result holds the back end; the queue keeps taking tokens until full.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int VAR_COUNT   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  opcode,
    input  logic [1:0]  arity,
    input  logic signed [31:0] token_value,
    input  logic        last_token,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] result_value,
    output logic        stack_fault,
    output logic        divide_fault
);
    import rpn_pkg::*;

    logic   q_valid, q_pop;
    token_t q_token;

    rpn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .arity       (arity),
        .token_value (token_value),
        .last_token  (last_token),
        .q_valid     (q_valid),
        .q_token     (q_token),
        .q_pop       (q_pop)
    );

    rpn_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .VAR_COUNT   (VAR_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_token      (q_token),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .stack_fault  (stack_fault),
        .divide_fault (divide_fault)
    );

    // Never pop an empty queue
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value))
        else $error("stalled result changed");
endmodule

/* test/rpn_stack_evaluator_checker.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_checker: prediction and comparison for the evaluator
// Watches both channels, runs its own Q16.16 stack machine on every accepted
// word and compares each emitted result with the oldest prediction.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_checker #(
    parameter int STACK_DEPTH = 16,
    parameter int VAR_COUNT   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [3:0]         opcode,
    input  logic [1:0]         arity,
    input  logic signed [31:0] token_value,
    input  logic               last_token,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] result_value,
    input  logic               stack_fault,
    input  logic               divide_fault,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rpn_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic               sfault;
        logic               dfault;
    } outcome_t;

    outcome_t           outcome_q[$];
    logic signed [31:0] stack_mem [STACK_DEPTH];
    logic signed [31:0] var_mem [VAR_COUNT];
    int                 depth;
    logic signed [31:0] latest;
    logic               sflag;
    logic               dflag;

    assign pending_count = outcome_q.size();

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            return SAT_MAX;
        if (v < -64'sh8000_0000)
            return SAT_MIN;
        return v[31:0];
    endfunction

    // Integer part toward zero, -1 when outside the table
    function automatic int table_slot(input logic signed [31:0] q);
        longint v;
        longint i;
        v = q;
        i = (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
        if (i < 0 || i >= VAR_COUNT)
            return -1;
        return int'(i);
    endfunction

    function automatic logic signed [31:0] take_top();
        if (depth == 0)
        begin
            sflag = 1'b1;
            return 32'sd0;
        end
        depth--;
        return stack_mem[depth];
    endfunction

    function automatic void put_top(input logic signed [31:0] v);
        if (depth >= STACK_DEPTH)
        begin
            sflag = 1'b1;
            return;
        end
        stack_mem[depth] = v;
        depth++;
    endfunction

    // Execute one token against the shadow machine
    function automatic void run_token(input opcode_t op, input logic [1:0] n,
                                      input logic signed [31:0] tv, input logic lst);
        logic signed [31:0] p [4];
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] prod;
        logic signed [31:0] r;
        logic               produces;
        int                 slot;
        outcome_t           o;
        p = '{default: 32'sd0};
        r = 32'sd0;
        produces = 1'b1;
        for (int k = n; k > 0; k--)
            p[k] = take_top();
        a = p[1];
        b = p[2];
        case (op)
            OP_NUM:
            begin
                put_top(tv);
                produces = 1'b0;
            end
            OP_VAR:
            begin
                slot = table_slot(tv);
                put_top(slot >= 0 ? var_mem[slot] : 32'sd0);
                produces = 1'b0;
            end
            OP_MUL:
            begin
                prod = a * b + 64'sh8000;
                r = clamp32(prod >>> 16);
            end
            OP_DIV:
            begin
                if (b == 0)
                begin
                    dflag = 1'b1;
                    r = (a > 0) ? SAT_MAX : (a < 0) ? SAT_MIN : 32'sd0;
                end
                else
                    r = clamp32((a * 64'sd65536) / b);
            end
            OP_ADD:    r = clamp32(a + b);
            OP_SUB:    r = clamp32(a - b);
            OP_PASS:   r = p[1];
            OP_NEG:    r = clamp32(-a);
            OP_LT:     r = (a < b) ? Q_ONE : 32'sd0;
            OP_LE:     r = (a <= b) ? Q_ONE : 32'sd0;
            OP_GT:     r = (a > b) ? Q_ONE : 32'sd0;
            OP_GE:     r = (a >= b) ? Q_ONE : 32'sd0;
            OP_EQ:     r = (a == b) ? Q_ONE : 32'sd0;
            OP_NE:     r = (a != b) ? Q_ONE : 32'sd0;
            OP_ASSIGN:
            begin
                slot = table_slot(p[1]);
                if (slot >= 0)
                    var_mem[slot] = p[2];
                produces = 1'b0;
            end
            default:   r = (p[1] != 0) ? p[2] : p[3];
        endcase
        if (produces)
        begin
            latest = r;
            put_top(r);
        end
        if (lst)
        begin
            o.value = latest;
            o.sfault = sflag;
            o.dfault = dflag;
            outcome_q = {outcome_q, o};
            depth = 0;
            latest = 32'sd0;
            sflag = 1'b0;
            dflag = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        if (!rst_n)
        begin
            outcome_q.delete();
            var_mem = '{default: 32'sd0};
            stack_mem = '{default: 32'sd0};
            depth = 0;
            latest = 32'sd0;
            sflag = 1'b0;
            dflag = 1'b0;
            fail_count <= 0;
        end
        else
        begin
            // Predict on every accepted input word
            if (in_valid && !in_stall)
                run_token(opcode_t'(opcode), arity, token_value, last_token);
            // Compare every accepted result word
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word: value %h sf %b df %b",
                                 result_value, stack_fault, divide_fault);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    o = outcome_q.pop_front();
                    if (result_value !== o.value || stack_fault !== o.sfault
                        || divide_fault !== o.dfault)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                                     o.value, o.sfault, o.dfault,
                                     result_value, stack_fault, divide_fault);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/rpn_stack_evaluator_test.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_test: stimulus and verdict for the evaluator
// Drives directed tokens, then random well-formed expressions mixed with
// noise, under random idle and stall; the checker judges every result.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rpn_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         opcode;
    logic [1:0]         arity;
    logic signed [31:0] token_value;
    logic               last_token;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_value;
    logic               stack_fault;
    logic               divide_fault;
    int                 fail_count;
    int                 pending_count;
    int                 word_count;

    rpn_stack_evaluator dut (.*);
    rpn_stack_evaluator_checker chk (.*);

    always #5 clk = ~clk;

    // Send one word: idle a random time, then hold until accepted
    task automatic send_word(input opcode_t op, input logic [1:0] n,
                             input logic signed [31:0] tv, input logic lst);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        arity <= n;
        token_value <= tv;
        last_token <= lst;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        word_count++;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return 32'sd0;
            3: return $signed($urandom_range(0, 20) << 16);
            4: return -$signed($urandom_range(0, 8) << 16);
            5: return $signed($urandom_range(0, 400000)) - 200000;
            default: return $signed($urandom());
        endcase
    endfunction

    // Random operator whose arity usually matches its use
    task automatic send_operator(input logic lst);
        opcode_t op;
        logic [1:0] n;
        op = opcode_t'($urandom_range(2, 15));
        if (op == OP_SELECT)
            n = 2'd3;
        else if (op == OP_PASS || op == OP_NEG)
            n = 2'd1;
        else
            n = 2'd2;
        if ($urandom_range(0, 9) == 0)
            n = 2'($urandom_range(0, 3));
        send_word(op, n, $signed($urandom()), lst);
    endtask

    // Stall the output at random, then release it and wait for a result word
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(0, 12);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int depth;
        int ops;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_NUM;
        arity = 2'd0;
        token_value = 32'sd0;
        last_token = 1'b0;
        word_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: saturation, divide by zero, underflow, variables, overflow
        send_word(OP_NUM, 2'd0, SAT_MAX, 1'b0);
        send_word(OP_NUM, 2'd0, SAT_MAX, 1'b0);
        send_word(OP_MUL, 2'd2, 32'sd0, 1'b0);
        send_word(OP_NUM, 2'd0, SAT_MIN, 1'b0);
        send_word(OP_NEG, 2'd1, 32'sd0, 1'b0);
        send_word(OP_NUM, 2'd0, 32'sd0, 1'b0);
        send_word(OP_DIV, 2'd2, 32'sd0, 1'b1);
        send_word(OP_SUB, 2'd3, 32'sd0, 1'b1);
        send_word(OP_NUM, 2'd0, 32'sh0003_8000, 1'b0);
        send_word(OP_NUM, 2'd0, -32'sd7, 1'b0);
        send_word(OP_ASSIGN, 2'd2, 32'sd0, 1'b0);
        send_word(OP_VAR, 2'd0, 32'sh0003_ffff, 1'b0);
        send_word(OP_VAR, 2'd0, -32'sh0000_8000, 1'b0);
        send_word(OP_VAR, 2'd0, 32'sh0010_0000, 1'b0);
        send_word(OP_SELECT, 2'd3, 32'sd0, 1'b1);
        for (int i = 0; i < 17; i++)
            send_word(OP_NUM, 2'd0, $signed(i << 16), 1'b0);
        send_word(OP_NE, 2'd2, 32'sd0, 1'b1);
        for (int op = OP_MUL; op <= OP_SELECT; op++)
            send_word(opcode_t'(op), 2'd3, 32'sd0, op == OP_SELECT);

        // Let the block drain completely once
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);

        // Random expressions with occasional noise
        while (word_count < 1045)
        begin
            depth = 0;
            ops = $urandom_range(1, 8);
            while (ops > 0)
            begin
                if (depth >= 2 && $urandom_range(0, 2) != 0)
                begin
                    send_operator(1'b0);
                    depth--;
                    ops--;
                end
                else if ($urandom_range(0, 5) == 0)
                    send_word(OP_VAR, 2'd0, $signed($urandom_range(0, 18) << 16), 1'b0);
                else if ($urandom_range(0, 15) == 0)
                begin
                    send_word(OP_NUM, 2'd0, $signed($urandom_range(0, 17) << 16), 1'b0);
                    send_word(OP_ASSIGN, 2'd2, 32'sd0, 1'b0);
                end
                else
                    send_word(OP_NUM, 2'd0, pick_value(), 1'b0);
                depth++;
            end
            send_operator(1'b1);
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
